/* rtl/lpr_pkg.sv */
// shared types, codes and sizes for the line pixel rasterizer
package lpr_pkg;

  // sizes
  localparam int COORD_BITS     = 12;
  localparam int ERR_BITS       = COORD_BITS + 1;
  localparam int COLOUR_BITS    = 16;
  localparam int CMD_DEPTH_DEF  = 4;
  localparam int RES_DEPTH_DEF  = 2;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // step direction codes, two's complement
  localparam logic [1:0] STEP_ZERO = 2'd0;
  localparam logic [1:0] STEP_POS  = 2'd1;
  localparam logic [1:0] STEP_NEG  = 2'd3;

  // input item
  typedef struct packed {
    logic                   kind;
    logic [COORD_BITS-1:0]  x_start;
    logic [COORD_BITS-1:0]  y_start;
    logic [COORD_BITS-1:0]  x_end;
    logic [COORD_BITS-1:0]  y_end;
    logic [COLOUR_BITS-1:0] pixel_colour;
  } lpr_in_t;

  // result item
  typedef struct packed {
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] colour_out;
    logic                   last_pixel;
  } lpr_out_t;

  // classified command between front and back
  typedef struct packed {
    logic                   kind;
    logic [COORD_BITS-1:0]  x_start;
    logic [COORD_BITS-1:0]  y_start;
    logic [COORD_BITS-1:0]  abs_dx;
    logic [COORD_BITS-1:0]  abs_dy;
    logic [1:0]             step_x;
    logic [1:0]             step_y;
    logic [COLOUR_BITS-1:0] colour;
  } lpr_cmd_t;

endpackage

/* rtl/lpr_fifo.sv */
// small first-word-fall-through queue
module lpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/lpr_front.sv */
// front end: accepts items, works out line deltas and step directions
module lpr_front
  import lpr_pkg::*;
(
  input  logic     push,
  input  lpr_in_t  cmd,
  output logic     full,
  input  logic     q_full,
  output logic     q_push,
  output lpr_cmd_t q_data
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [1:0]            sx;
  logic [1:0]            sy;

  // x axis delta and direction
  always_comb begin
    priority if (cmd.x_end > cmd.x_start) begin
      dx = cmd.x_end - cmd.x_start;
      sx = STEP_POS;
    end else if (cmd.x_end == cmd.x_start) begin
      dx = '0;
      sx = STEP_ZERO;
    end else begin
      dx = cmd.x_start - cmd.x_end;
      sx = STEP_NEG;
    end
  end

  // y axis delta and direction
  always_comb begin
    priority if (cmd.y_end > cmd.y_start) begin
      dy = cmd.y_end - cmd.y_start;
      sy = STEP_POS;
    end else if (cmd.y_end == cmd.y_start) begin
      dy = '0;
      sy = STEP_ZERO;
    end else begin
      dy = cmd.y_start - cmd.y_end;
      sy = STEP_NEG;
    end
  end

  // command toward the back end
  always_comb begin
    q_data.kind    = cmd.kind;
    q_data.x_start = cmd.x_start;
    q_data.y_start = cmd.y_start;
    q_data.abs_dx  = dx;
    q_data.abs_dy  = dy;
    q_data.step_x  = sx;
    q_data.step_y  = sy;
    q_data.colour  = cmd.pixel_colour;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

/* rtl/lpr_back.sv */
// back end: holds the line in progress and steps it one pixel per tick
module lpr_back
  import lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  lpr_cmd_t cmd,
  output logic     cmd_take,
  input  logic     res_full,
  output logic     res_push,
  output lpr_out_t res
);

  logic                   active;
  logic [COORD_BITS-1:0]  cur_x;
  logic [COORD_BITS-1:0]  cur_y;
  logic [COORD_BITS-1:0]  abs_dx;
  logic [COORD_BITS-1:0]  abs_dy;
  logic [COORD_BITS-1:0]  major;
  logic [1:0]             step_x;
  logic [1:0]             step_y;
  logic [ERR_BITS-1:0]    err_x;
  logic [ERR_BITS-1:0]    err_y;
  logic [ERR_BITS-1:0]    pixels_left;
  logic [COLOUR_BITS-1:0] colour;

  logic [ERR_BITS-1:0]    sum_x;
  logic [ERR_BITS-1:0]    sum_y;
  logic                   hit_x;
  logic                   hit_y;
  logic [ERR_BITS-1:0]    err_x_next;
  logic [ERR_BITS-1:0]    err_y_next;
  logic [COORD_BITS-1:0]  cur_x_next;
  logic [COORD_BITS-1:0]  cur_y_next;
  logic [COORD_BITS-1:0]  major_next;
  logic                   is_start;
  logic                   is_tick;

  // move a coordinate one step in the coded direction
  function automatic logic [COORD_BITS-1:0] step_pos(
    input logic [COORD_BITS-1:0] pos,
    input logic [1:0]            dir
  );
    logic [COORD_BITS-1:0] r;
    unique case (dir)
      STEP_POS: r = pos + 1'b1;
      STEP_NEG: r = pos - 1'b1;
      default:  r = pos;
    endcase
    return r;
  endfunction

  // handshake toward both queues
  assign is_start = (cmd.kind == KIND_START);
  assign is_tick  = (cmd.kind == KIND_TICK);
  assign cmd_take = cmd_valid && (is_start || !active || !res_full);
  assign res_push = cmd_take && is_tick && active;

  // current pixel
  always_comb begin
    res.pixel_x    = cur_x;
    res.pixel_y    = cur_y;
    res.colour_out = colour;
    res.last_pixel = (pixels_left == ERR_BITS'(1));
  end

  // error accumulation per axis
  always_comb begin
    sum_x      = err_x + {1'b0, abs_dx};
    sum_y      = err_y + {1'b0, abs_dy};
    hit_x      = (sum_x >= {1'b0, major});
    hit_y      = (sum_y >= {1'b0, major});
    err_x_next = hit_x ? sum_x - {1'b0, major} : sum_x;
    err_y_next = hit_y ? sum_y - {1'b0, major} : sum_y;
    cur_x_next = hit_x ? step_pos(cur_x, step_x) : cur_x;
    cur_y_next = hit_y ? step_pos(cur_y, step_y) : cur_y;
    major_next = (cmd.abs_dx > cmd.abs_dy) ? cmd.abs_dx : cmd.abs_dy;
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      major       <= '0;
      step_x      <= STEP_ZERO;
      step_y      <= STEP_ZERO;
      err_x       <= '0;
      err_y       <= '0;
      pixels_left <= '0;
      colour      <= '0;
    end else if (cmd_take) begin
      if (is_start) begin
        active      <= 1'b1;
        cur_x       <= cmd.x_start;
        cur_y       <= cmd.y_start;
        abs_dx      <= cmd.abs_dx;
        abs_dy      <= cmd.abs_dy;
        major       <= major_next;
        step_x      <= cmd.step_x;
        step_y      <= cmd.step_y;
        err_x       <= '0;
        err_y       <= '0;
        pixels_left <= {1'b0, major_next} + 1'b1;
        colour      <= cmd.colour;
      end else if (active) begin
        if (pixels_left <= ERR_BITS'(1)) begin
          active      <= 1'b0;
          pixels_left <= '0;
        end else begin
          pixels_left <= pixels_left - 1'b1;
          err_x       <= err_x_next;
          err_y       <= err_y_next;
          cur_x       <= cur_x_next;
          cur_y       <= cur_y_next;
        end
      end
    end
  end

endmodule

/* rtl/line_pixel_rasterizer.sv */
// top level of the line pixel rasterizer
//
//   channel   handshake          payload     role
//   input     push / full        cmd         start or tick items
//   result    empty / pop        pixel       one pixel per tick of an active line
//
// one item per clock sustained while the result queue has room. a tick's
// pixel goes through the command queue and the result queue to the result
// ports. each tick does one add, compare and subtract per axis in the back
// end. reset clears both queues and drops any line in progress.
// with pop held low the result queue fills, the back end stops taking the
// ticks of an active line, and full rises once the command queue is full.
module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  lpr_in_t  cmd,
  output logic     empty,
  input  logic     pop,
  output lpr_out_t pixel
);

  logic     cmd_push;
  lpr_cmd_t cmd_wdata;
  logic     cmd_full;
  lpr_cmd_t cmd_rdata;
  logic     cmd_empty;
  logic     cmd_take;
  logic     res_push;
  lpr_out_t res_wdata;
  logic     res_full;
  lpr_out_t res_rdata;

  // classify and set up
  lpr_front u_front (
    .push   (push),
    .cmd    (cmd),
    .full   (full),
    .q_full (cmd_full),
    .q_push (cmd_push),
    .q_data (cmd_wdata)
  );

  // command queue between front and back
  lpr_fifo #(
    .WIDTH ($bits(lpr_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_take),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // line stepping
  lpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_rdata),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wdata)
  );

  // result queue
  lpr_fifo #(
    .WIDTH ($bits(lpr_out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign pixel = res_rdata;

  // back end never writes a pixel into a full result queue
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("pixel written into full result queue");

  // back end only takes a command that is there
  a_cmd_there: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !cmd_empty)
    else $error("command taken from empty queue");

  // an accepted item is waiting in the command queue on the next cycle
  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !cmd_empty)
    else $error("accepted item missing from command queue");

endmodule
